// ----- rtl/rbre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rbre_pkg;

    typedef struct packed {
        logic        [2:0]  kind;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic signed [11:0] src_x;
        logic signed [11:0] src_y;
        logic signed [11:0] area_w;
        logic signed [11:0] area_h;
        logic        [9:0]  radius;
        logic        [31:0] color;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        in_range;
    } t_out_item;

    typedef enum logic [2:0] {
        KIND_LOAD_DST = 3'd0,
        KIND_LOAD_SRC = 3'd1,
        KIND_READ     = 3'd2,
        KIND_PIXEL    = 3'd3,
        KIND_RECT     = 3'd4,
        KIND_CIRCLE   = 3'd5,
        KIND_TILE     = 3'd6,
        KIND_SPRITE   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        OP_LOAD_DST,
        OP_LOAD_SRC,
        OP_READ,
        OP_BLEND,
        OP_COPY,
        OP_SPRITE
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CALC,
        ST_RD,
        ST_WR,
        ST_DONE
    } t_state;

    localparam logic [1:0] REG_DEST_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DEST_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SRC_WIDTH   = 2'd2;
    localparam logic [1:0] REG_SRC_HEIGHT  = 2'd3;

    localparam logic [8:0] DIM_RESET = 9'd256;

    typedef logic signed [13:0] t_coord;

    function automatic t_coord clampc(input t_coord v, input t_coord lo, input t_coord hi);
        t_coord res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // per channel (a*f+(255-a)*b)/255, alpha forced to 255
    function automatic logic [31:0] mix(input logic [31:0] fg, input logic [31:0] bg);
        logic [7:0]  a;
        logic [15:0] p0;
        logic [15:0] p1;
        logic [15:0] n;
        logic [16:0] q;
        logic [31:0] res;
        int          c;
        a   = fg[7:0];
        res = {24'h0, 8'hff};
        for (c = 1; c < 4; c++) begin
            p0 = {8'h0, a} * {8'h0, fg[8*c +: 8]};
            p1 = {8'h0, 8'hff - a} * {8'h0, bg[8*c +: 8]};
            n  = p0 + p1;
            // exact divide by 255 for n below 65535
            q  = {1'b0, n} + {9'h0, n[15:8]} + 17'd1;
            res[8*c +: 8] = q[15:8];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rgba_blend_raster_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// RGBA8888 2D raster engine: loads, read-back, single pixel blend, clipped rectangle fill,
// disc fill, tile copy and sprite copy over a destination and a source surface held in two
// single-port-write synchronous RAMs. One command at a time. A command passes a setup state,
// then three states for every pixel position it visits (index multiply, RAM read, blend and
// write back), then a done state that hands its result to the output register once that
// register can take it. A disc visits its clipped bounding square. The read-modify-write on
// the destination RAM sets the per-pixel steps. A new command is taken while the previous
// result still waits at the output register.
module rgba_blend_raster_engine #(
    parameter int DEST_PIXELS   = 65536,
    parameter int SOURCE_PIXELS = 65536
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire rbre_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rbre_pkg::t_out_item       o_out_data
);

    localparam int DAW = $clog2(DEST_PIXELS);
    localparam int SAW = $clog2(SOURCE_PIXELS);

    logic [8:0] r_dest_w, r_dest_h, r_src_w, r_src_h;

    rbre_pkg::t_state    r_state, n_state;
    rbre_pkg::t_in_item  r_cmd;
    rbre_pkg::t_op       r_op;
    logic                r_circ;
    rbre_pkg::t_coord    r_i, r_j, r_jlo, r_ihi, r_jhi;
    rbre_pkg::t_coord    r_xoff, r_yoff, r_sxoff, r_syoff;
    logic [19:0]         r_rr;
    logic [17:0]         r_didx, r_sidx;
    logic                r_dpre, r_spre;
    logic signed [27:0]  r_ii, r_jj;
    logic                r_dok, r_sok, r_hit;
    logic [31:0]         r_value;
    logic                r_ok;
    logic                r_ovalid;
    rbre_pkg::t_out_item r_odata;

    logic in_fire, out_fire, out_load, last;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w <= rbre_pkg::DIM_RESET;
            r_dest_h <= rbre_pkg::DIM_RESET;
            r_src_w  <= rbre_pkg::DIM_RESET;
            r_src_h  <= rbre_pkg::DIM_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                rbre_pkg::REG_DEST_WIDTH:  r_dest_w <= pwdata[8:0];
                rbre_pkg::REG_DEST_HEIGHT: r_dest_h <= pwdata[8:0];
                rbre_pkg::REG_SRC_WIDTH:   r_src_w  <= pwdata[8:0];
                rbre_pkg::REG_SRC_HEIGHT:  r_src_h  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rbre_pkg::REG_DEST_WIDTH:  prdata = {23'h0, r_dest_w};
            rbre_pkg::REG_DEST_HEIGHT: prdata = {23'h0, r_dest_h};
            rbre_pkg::REG_SRC_WIDTH:   prdata = {23'h0, r_src_w};
            rbre_pkg::REG_SRC_HEIGHT:  prdata = {23'h0, r_src_h};
            default:                   prdata = 32'h0;
        endcase
    end

    // command setup: walk ranges (inclusive) and offsets
    rbre_pkg::t_coord px, py, sx, sy, aw, ah, rad, dw, dh, sw, sh, ex, ey;
    rbre_pkg::t_coord s_ilo, s_ihi, s_jlo, s_jhi, s_xoff, s_yoff, s_sxoff, s_syoff;
    rbre_pkg::t_op    s_op;
    logic             s_circ, s_reject, s_empty;

    always_comb begin
        px  = rbre_pkg::t_coord'(r_cmd.pos_x);
        py  = rbre_pkg::t_coord'(r_cmd.pos_y);
        sx  = rbre_pkg::t_coord'(r_cmd.src_x);
        sy  = rbre_pkg::t_coord'(r_cmd.src_y);
        aw  = rbre_pkg::t_coord'(r_cmd.area_w);
        ah  = rbre_pkg::t_coord'(r_cmd.area_h);
        rad = rbre_pkg::t_coord'({4'h0, r_cmd.radius});
        dw  = rbre_pkg::t_coord'({5'h0, r_dest_w});
        dh  = rbre_pkg::t_coord'({5'h0, r_dest_h});
        sw  = rbre_pkg::t_coord'({5'h0, r_src_w});
        sh  = rbre_pkg::t_coord'({5'h0, r_src_h});
        ex  = sx + aw - 14'sd1;
        ey  = sy + ah - 14'sd1;
        s_ilo    = '0;
        s_ihi    = '0;
        s_jlo    = '0;
        s_jhi    = '0;
        s_xoff   = px;
        s_yoff   = py;
        s_sxoff  = sx;
        s_syoff  = sy;
        s_op     = rbre_pkg::OP_BLEND;
        s_circ   = 1'b0;
        s_reject = 1'b0;
        case (rbre_pkg::t_kind'(r_cmd.kind))
            rbre_pkg::KIND_LOAD_DST: s_op = rbre_pkg::OP_LOAD_DST;
            rbre_pkg::KIND_LOAD_SRC: s_op = rbre_pkg::OP_LOAD_SRC;
            rbre_pkg::KIND_READ:     s_op = rbre_pkg::OP_READ;
            rbre_pkg::KIND_PIXEL:    s_op = rbre_pkg::OP_BLEND;
            rbre_pkg::KIND_RECT: begin
                s_xoff = '0;
                s_yoff = '0;
                s_ilo  = rbre_pkg::clampc(py, 14'sd0, dh);
                s_ihi  = rbre_pkg::clampc(py + ah, 14'sd0, dh) - 14'sd1;
                s_jlo  = rbre_pkg::clampc(px, 14'sd0, dw);
                s_jhi  = rbre_pkg::clampc(px + aw, 14'sd0, dw) - 14'sd1;
            end
            rbre_pkg::KIND_CIRCLE: begin
                s_circ = 1'b1;
                s_ilo  = rbre_pkg::clampc(-py, -rad, rad + 14'sd1);
                s_ihi  = rbre_pkg::clampc(dh - 14'sd1 - py, -rad - 14'sd1, rad);
                s_jlo  = rbre_pkg::clampc(-px, -rad, rad + 14'sd1);
                s_jhi  = rbre_pkg::clampc(dw - 14'sd1 - px, -rad - 14'sd1, rad);
            end
            rbre_pkg::KIND_TILE: begin
                s_op     = rbre_pkg::OP_COPY;
                s_reject = (sx < 0) || (sy < 0) || (sx + aw > sw) || (sy + ah > sh);
                s_ihi    = ah - 14'sd1;
                s_jhi    = aw - 14'sd1;
            end
            rbre_pkg::KIND_SPRITE: begin
                s_op     = rbre_pkg::OP_SPRITE;
                s_reject = (sx < 0) || (sy < 0) || (sx >= sw) || (sy >= sh) ||
                           (ex < 0) || (ey < 0) || (ex >= sw) || (ey >= sh);
                s_ihi    = ah - 14'sd1;
                s_jhi    = aw - 14'sd1;
            end
            default: ;
        endcase
        s_empty = s_reject || (s_ilo > s_ihi) || (s_jlo > s_jhi);
    end

    // memories
    logic            dst_we, dst_re, src_we, src_re;
    logic [31:0]     dst_wdata, src_wdata, dst_rdata, src_rdata, spr_pixel;
    logic            res_ok, res_ld_value;

    rbre_ram #(.WIDTH(32), .DEPTH(DEST_PIXELS)) u_dest_ram (
        .i_clk   (i_clk),
        .i_we    (dst_we),
        .i_waddr (DAW'(r_didx)),
        .i_wdata (dst_wdata),
        .i_re    (dst_re),
        .i_raddr (DAW'(r_didx)),
        .o_rdata (dst_rdata)
    );

    rbre_ram #(.WIDTH(32), .DEPTH(SOURCE_PIXELS)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (SAW'(r_sidx)),
        .i_wdata (src_wdata),
        .i_re    (src_re),
        .i_raddr (SAW'(r_sidx)),
        .o_rdata (src_rdata)
    );

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = r_ovalid && !i_out_stall;
    assign last     = (r_j == r_jhi) && (r_i == r_ihi);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbre_pkg::ST_IDLE:  if (in_fire) n_state = rbre_pkg::ST_SETUP;
            rbre_pkg::ST_SETUP: n_state = s_empty ? rbre_pkg::ST_DONE : rbre_pkg::ST_CALC;
            rbre_pkg::ST_CALC:  n_state = rbre_pkg::ST_RD;
            rbre_pkg::ST_RD:    n_state = rbre_pkg::ST_WR;
            rbre_pkg::ST_WR:    n_state = last ? rbre_pkg::ST_DONE : rbre_pkg::ST_CALC;
            rbre_pkg::ST_DONE:  if (!r_ovalid || !i_out_stall) n_state = rbre_pkg::ST_IDLE;
            default:            n_state = rbre_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        // no transfer is taken while reset is held
        o_in_stall   = (r_state != rbre_pkg::ST_IDLE) || !i_rst_n;
        out_load     = (r_state == rbre_pkg::ST_DONE) && (!r_ovalid || !i_out_stall);
        dst_re       = (r_state == rbre_pkg::ST_RD);
        src_re       = (r_state == rbre_pkg::ST_RD);
        dst_we       = 1'b0;
        src_we       = 1'b0;
        dst_wdata    = r_cmd.color;
        src_wdata    = r_cmd.color;
        res_ok       = 1'b0;
        res_ld_value = 1'b0;
        spr_pixel    = r_sok ? src_rdata : 32'h0;
        if (r_state == rbre_pkg::ST_WR) begin
            case (r_op)
                rbre_pkg::OP_LOAD_DST: begin
                    dst_we = r_dok;
                    res_ok = r_dok;
                end
                rbre_pkg::OP_LOAD_SRC: begin
                    src_we = r_sok;
                    res_ok = r_sok;
                end
                rbre_pkg::OP_READ: begin
                    res_ok       = r_dok;
                    res_ld_value = r_dok;
                end
                rbre_pkg::OP_BLEND: begin
                    dst_we    = r_dok && r_hit;
                    dst_wdata = rbre_pkg::mix(r_cmd.color, dst_rdata);
                end
                rbre_pkg::OP_COPY: begin
                    dst_we    = r_dok;
                    dst_wdata = spr_pixel;
                end
                rbre_pkg::OP_SPRITE: begin
                    dst_we    = r_dok && (spr_pixel[7:0] != 8'h0);
                    dst_wdata = rbre_pkg::mix(spr_pixel, dst_rdata);
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rbre_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (out_fire) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    rbre_pkg::t_coord dx, dy, qx, qy;
    assign dx = r_xoff + r_j;
    assign dy = r_yoff + r_i;
    assign qx = r_sxoff + r_j;
    assign qy = r_syoff + r_i;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_data;
        end
        if (out_load) begin
            r_odata <= '{pixel_value: r_value, in_range: r_ok};
        end
        case (r_state)
            rbre_pkg::ST_SETUP: begin
                r_op    <= s_op;
                r_circ  <= s_circ;
                r_i     <= s_ilo;
                r_j     <= s_jlo;
                r_jlo   <= s_jlo;
                r_ihi   <= s_ihi;
                r_jhi   <= s_jhi;
                r_xoff  <= s_xoff;
                r_yoff  <= s_yoff;
                r_sxoff <= s_sxoff;
                r_syoff <= s_syoff;
                r_rr    <= {10'h0, r_cmd.radius} * {10'h0, r_cmd.radius};
                r_value <= 32'h0;
                r_ok    <= 1'b0;
            end
            rbre_pkg::ST_CALC: begin
                r_dpre <= (dx >= 0) && (dy >= 0) &&
                          (dx < rbre_pkg::t_coord'({5'h0, r_dest_w})) &&
                          (dy < rbre_pkg::t_coord'({5'h0, r_dest_h}));
                r_spre <= (qx >= 0) && (qy >= 0) &&
                          (qx < rbre_pkg::t_coord'({5'h0, r_src_w})) &&
                          (qy < rbre_pkg::t_coord'({5'h0, r_src_h}));
                r_didx <= {9'h0, dy[8:0]} * {9'h0, r_dest_w} + {9'h0, dx[8:0]};
                r_sidx <= {9'h0, qy[8:0]} * {9'h0, r_src_w} + {9'h0, qx[8:0]};
                r_ii   <= r_i * r_i;
                r_jj   <= r_j * r_j;
            end
            rbre_pkg::ST_RD: begin
                r_dok <= r_dpre && ({14'h0, r_didx} < 32'(DEST_PIXELS));
                r_sok <= r_spre && ({14'h0, r_sidx} < 32'(SOURCE_PIXELS));
                r_hit <= !r_circ || ((r_ii + r_jj) <= $signed({8'h0, r_rr}));
            end
            rbre_pkg::ST_WR: begin
                if (r_op == rbre_pkg::OP_LOAD_DST || r_op == rbre_pkg::OP_LOAD_SRC ||
                    r_op == rbre_pkg::OP_READ) begin
                    r_ok <= res_ok;
                end
                if (res_ld_value) begin
                    r_value <= dst_rdata;
                end
                if (r_j != r_jhi) begin
                    r_j <= r_j + 14'sd1;
                end else begin
                    r_j <= r_jlo;
                    r_i <= r_i + 14'sd1;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_write_in_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dst_we || src_we) |-> (r_state == rbre_pkg::ST_WR))
        else $error("surface write outside write-back cycle");

    a_accept_to_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == rbre_pkg::ST_SETUP))
        else $error("accepted command did not enter setup");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == rbre_pkg::ST_DONE))
        else $error("result loaded outside done");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbre_pkg::ST_WR && r_op == rbre_pkg::OP_READ) |-> !(dst_we || src_we))
        else $error("read command wrote a surface");

endmodule
`default_nettype wire

// ----- rtl/rbre_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- test/tb_rgba_blend_checker.sv -----
`timescale 1ns / 1ps
module tb_rgba_blend_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  rbre_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  rbre_pkg::t_out_item i_out_data,
    output int                  o_errors,
    output int                  o_pending
);

    logic [31:0] dst_mem [65536];
    logic [31:0] src_mem [65536];
    int dst_w = 256, dst_h = 256, src_w = 256, src_h = 256;
    rbre_pkg::t_out_item result_q[$];
    int err_cnt = 0;

    function automatic bit dst_pos(input int x, input int y, output int idx);
        if (x < 0 || y < 0 || x >= dst_w || y >= dst_h) return 0;
        idx = y * dst_w + x;
        return idx < 65536;
    endfunction

    function automatic bit src_pos(input int x, input int y, output int idx);
        if (x < 0 || y < 0 || x >= src_w || y >= src_h) return 0;
        idx = y * src_w + x;
        return idx < 65536;
    endfunction

    function automatic logic [31:0] src_pixel(input int x, input int y);
        int idx;
        return src_pos(x, y, idx) ? src_mem[idx] : 32'h0;
    endfunction

    function automatic logic [31:0] blend_rgba(input logic [31:0] fg, input logic [31:0] bg);
        int a, f, b, sh;
        logic [31:0] res;
        a   = fg[7:0];
        res = 32'hff;
        for (sh = 8; sh <= 24; sh += 8) begin
            f = (fg >> sh) & 255;
            b = (bg >> sh) & 255;
            res[sh +: 8] = 8'((a * f + (255 - a) * b) / 255);
        end
        return res;
    endfunction

    function automatic void blend_dst(input int x, input int y, input logic [31:0] color);
        int idx;
        if (dst_pos(x, y, idx)) dst_mem[idx] = blend_rgba(color, dst_mem[idx]);
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic rbre_pkg::t_out_item draw_cmd(input rbre_pkg::t_in_item c);
        rbre_pkg::t_out_item res;
        int px, py, sx, sy, w, h, r, i, j, idx, x0, y0, x1, y1, ex, ey;
        logic [31:0] p;
        px = $signed(c.pos_x);
        py = $signed(c.pos_y);
        sx = $signed(c.src_x);
        sy = $signed(c.src_y);
        w  = $signed(c.area_w);
        h  = $signed(c.area_h);
        r  = c.radius;
        res = '0;
        case (rbre_pkg::t_kind'(c.kind))
            rbre_pkg::KIND_LOAD_DST: begin
                if (dst_pos(px, py, idx)) begin
                    dst_mem[idx] = c.color;
                    res.in_range = 1'b1;
                end
            end
            rbre_pkg::KIND_LOAD_SRC: begin
                if (src_pos(sx, sy, idx)) begin
                    src_mem[idx] = c.color;
                    res.in_range = 1'b1;
                end
            end
            rbre_pkg::KIND_READ: begin
                if (dst_pos(px, py, idx)) begin
                    res.pixel_value = dst_mem[idx];
                    res.in_range    = 1'b1;
                end
            end
            rbre_pkg::KIND_PIXEL: blend_dst(px, py, c.color);
            rbre_pkg::KIND_RECT: begin
                x0 = clip(px, 0, dst_w);
                y0 = clip(py, 0, dst_h);
                x1 = clip(px + w, 0, dst_w);
                y1 = clip(py + h, 0, dst_h);
                for (i = y0; i < y1; i++)
                    for (j = x0; j < x1; j++) blend_dst(j, i, c.color);
            end
            rbre_pkg::KIND_CIRCLE: begin
                y0 = clip(-py, -r, r + 1);
                y1 = clip(dst_h - 1 - py, -r - 1, r);
                x0 = clip(-px, -r, r + 1);
                x1 = clip(dst_w - 1 - px, -r - 1, r);
                for (i = y0; i <= y1; i++)
                    for (j = x0; j <= x1; j++)
                        if (i * i + j * j <= r * r) blend_dst(px + j, py + i, c.color);
            end
            rbre_pkg::KIND_TILE: begin
                if (!(sx < 0 || sy < 0 || sx + w > src_w || sy + h > src_h)) begin
                    for (i = 0; i < h; i++)
                        for (j = 0; j < w; j++)
                            if (dst_pos(px + j, py + i, idx))
                                dst_mem[idx] = src_pixel(sx + j, sy + i);
                end
            end
            default: begin
                ex = sx + w - 1;
                ey = sy + h - 1;
                if (!(sx < 0 || sy < 0 || sx >= src_w || sy >= src_h ||
                      ex < 0 || ey < 0 || ex >= src_w || ey >= src_h)) begin
                    for (i = 0; i < h; i++)
                        for (j = 0; j < w; j++) begin
                            p = src_pixel(sx + j, sy + i);
                            // transparent sprite pixels leave the destination alone
                            if (p[7:0] != 8'h0) blend_dst(px + j, py + i, p);
                        end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        rbre_pkg::t_out_item want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    rbre_pkg::REG_DEST_WIDTH:  dst_w = pwdata[8:0];
                    rbre_pkg::REG_DEST_HEIGHT: dst_h = pwdata[8:0];
                    rbre_pkg::REG_SRC_WIDTH:   src_w = pwdata[8:0];
                    rbre_pkg::REG_SRC_HEIGHT:  src_h = pwdata[8:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result with nothing expected: %h", $realtime, i_out_data);
                end else begin
                    want = result_q.pop_front();
                    if (want.pixel_value !== i_out_data.pixel_value ||
                        want.in_range !== i_out_data.in_range) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: mismatch pixel_value exp %h got %h, %s %b got %b",
                                     $realtime, want.pixel_value, i_out_data.pixel_value,
                                     "in_range exp", want.in_range, i_out_data.in_range);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) result_q.push_back(draw_cmd(i_in_data));
        end
        o_errors  <= err_cnt;
        o_pending <= result_q.size();
    end

endmodule

// ----- test/tb_rgba_blend_raster_engine.sv -----
`timescale 1ns / 1ps
module tb_rgba_blend_raster_engine;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    rbre_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    rbre_pkg::t_out_item o_out_data;
    int                  errors, pending;

    int dw = 256, dh = 256, sw = 256, sh = 256;
    int cmd_count = 0;
    bit no_idle = 0;
    bit hold_req = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    rgba_blend_raster_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    tb_rgba_blend_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_cmd(input rbre_pkg::t_in_item c);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (o_in_stall);
        cmd_count++;
    endtask

    task automatic reg_write(input logic [1:0] idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_dims(input int a, input int b, input int c, input int d);
        reg_write(rbre_pkg::REG_DEST_WIDTH, a);
        reg_write(rbre_pkg::REG_DEST_HEIGHT, b);
        reg_write(rbre_pkg::REG_SRC_WIDTH, c);
        reg_write(rbre_pkg::REG_SRC_HEIGHT, d);
        dw = a;
        dh = b;
        sw = c;
        sh = d;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        // the pending count is registered and lags the last transfer
        @(posedge i_clk);
        while (pending != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    function automatic rbre_pkg::t_in_item make_cmd(input rbre_pkg::t_kind k,
                                                    input int px, input int py,
                                                    input int sx, input int sy, input int w,
                                                    input int h, input int r,
                                                    input logic [31:0] color);
        rbre_pkg::t_in_item c;
        c.kind   = k;
        c.pos_x  = 12'(px);
        c.pos_y  = 12'(py);
        c.src_x  = 12'(sx);
        c.src_y  = 12'(sy);
        c.area_w = 12'(w);
        c.area_h = 12'(h);
        c.radius = 10'(r);
        c.color  = color;
        return c;
    endfunction

    function automatic int near_coord(input int span);
        if ($urandom_range(0, 9) == 0) return $signed(12'($urandom));
        return $urandom_range(0, span + 16) - 8;
    endfunction

    function automatic logic [31:0] rand_color();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 4))
            0: c[7:0] = 8'h00;
            1: c[7:0] = 8'hff;
            default: ;
        endcase
        return c;
    endfunction

    function automatic rbre_pkg::t_in_item rand_cmd();
        rbre_pkg::t_in_item c;
        int r;
        c = make_cmd(rbre_pkg::t_kind'($urandom_range(0, 7)), near_coord(dw), near_coord(dh),
                     near_coord(sw), near_coord(sh), $urandom_range(0, 14) - 2,
                     $urandom_range(0, 14) - 2, $urandom_range(0, 10), rand_color());
        r = $urandom_range(0, 99);
        if (r < 15) c.kind = rbre_pkg::KIND_LOAD_DST;
        else if (r < 30) c.kind = rbre_pkg::KIND_LOAD_SRC;
        else if (r < 45) c.kind = rbre_pkg::KIND_READ;
        // occasional full-range sizes, clipped or rejected by the block
        if ($urandom_range(0, 9) == 0) c.area_w = 12'($urandom);
        if ($urandom_range(0, 9) == 0) c.area_h = 12'($urandom);
        if ($urandom_range(0, 14) == 0) c.radius = 10'($urandom);
        // sprites and tiles mostly well formed so they actually draw
        if ((c.kind == rbre_pkg::KIND_TILE || c.kind == rbre_pkg::KIND_SPRITE) &&
            sw > 0 && sh > 0 && $urandom_range(0, 3) != 0) begin
            c.src_x  = 12'($urandom_range(0, sw - 1));
            c.src_y  = 12'($urandom_range(0, sh - 1));
            c.area_w = 12'($urandom_range(1, (sw - c.src_x) < 12 ? sw - c.src_x : 12));
            c.area_h = 12'($urandom_range(1, (sh - c.src_y) < 12 ? sh - c.src_y : 12));
        end
        return c;
    endfunction

    // receiver side: random stalls, one long hold-off on request
    initial begin : out_side
        int r, n;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (no_idle || r < 50) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(1, 4);
                end else if (r < 92) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(8, 30);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : stim
        int x, y, ph, n;
        int dims [6][4] = '{'{8, 8, 16, 16}, '{64, 4, 4, 64}, '{0, 5, 64, 4},
                            '{1, 1, 0, 0}, '{256, 1, 256, 1}, '{7, 9, 13, 11}};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // index range 0..255 of both surfaces gets written, every later setting stays inside it
        set_dims(16, 16, 16, 16);
        for (y = 0; y < 16; y++)
            for (x = 0; x < 16; x++) begin
                send_cmd(make_cmd(rbre_pkg::KIND_LOAD_DST, x, y, 0, 0, 0, 0, 0, rand_color()));
                send_cmd(make_cmd(rbre_pkg::KIND_LOAD_SRC, 0, 0, x, y, 0, 0, 0, rand_color()));
            end

        send_cmd(make_cmd(rbre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_READ, 15, 15, 0, 0, 0, 0, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_READ, -2048, 2047, 0, 0, 0, 0, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_LOAD_DST, 16, 0, 0, 0, 0, 0, 0, 32'hffffffff));
        send_cmd(make_cmd(rbre_pkg::KIND_LOAD_SRC, 0, 0, -2048, 2047, 0, 0, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_LOAD_SRC, 0, 0, 2, 2, 0, 0, 0, 32'h12345600));
        send_cmd(make_cmd(rbre_pkg::KIND_PIXEL, 5, 5, 0, 0, 0, 0, 0, 32'hffffffff));
        send_cmd(make_cmd(rbre_pkg::KIND_PIXEL, 6, 6, 0, 0, 0, 0, 0, 32'h12345600));
        send_cmd(make_cmd(rbre_pkg::KIND_PIXEL, -1, 3, 0, 0, 0, 0, 0, 32'h808080ff));
        send_cmd(make_cmd(rbre_pkg::KIND_RECT, -3, -3, 0, 0, 8, 6, 0, 32'h40c02080));
        send_cmd(make_cmd(rbre_pkg::KIND_RECT, 4, 4, 0, 0, 0, 5, 0, 32'hffffffff));
        send_cmd(make_cmd(rbre_pkg::KIND_RECT, 4, 4, 0, 0, -2048, 5, 0, 32'hffffffff));
        send_cmd(make_cmd(rbre_pkg::KIND_RECT, 10, 10, 0, 0, 2047, 2047, 0, 32'h11223344));
        send_cmd(make_cmd(rbre_pkg::KIND_CIRCLE, 10, 10, 0, 0, 0, 0, 0, 32'hff0000ff));
        send_cmd(make_cmd(rbre_pkg::KIND_CIRCLE, 8, 8, 0, 0, 0, 0, 1023, 32'h00ff0010));
        send_cmd(make_cmd(rbre_pkg::KIND_CIRCLE, -2048, -2048, 0, 0, 0, 0, 5, 32'hffffffff));
        send_cmd(make_cmd(rbre_pkg::KIND_CIRCLE, 15, 0, 0, 0, 0, 0, 4, 32'h0000ff7f));
        send_cmd(make_cmd(rbre_pkg::KIND_TILE, 3, 4, 0, 0, 8, 8, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_TILE, 3, 4, -1, 0, 4, 4, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_TILE, 3, 4, 14, 0, 4, 4, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_TILE, 3, 4, 0, 0, -3, 4, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_SPRITE, 12, 12, 0, 0, 6, 6, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_SPRITE, 0, 0, 14, 0, 4, 4, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_SPRITE, 0, 0, -1, 0, 4, 4, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_READ, 3, 4, 0, 0, 0, 0, 0, 32'h0));
        send_cmd(make_cmd(rbre_pkg::KIND_READ, 12, 12, 0, 0, 0, 0, 0, 32'h0));

        for (ph = 0; ph < 6; ph++) begin
            i_in_valid <= 1'b0;
            drain();
            set_dims(dims[ph][0], dims[ph][1], dims[ph][2], dims[ph][3]);
            no_idle = (ph == 4);
            for (n = 0; n < 135; n++) begin
                if (ph == 1 && n == 40) hold_req = 1;
                send_cmd(rand_cmd());
            end
        end
        i_in_valid <= 1'b0;
        no_idle = 1;
        drain();
        $display("sent %0d commands of all eight kinds over seven surface size settings",
                 cmd_count);
        $display("including zero and full-width surfaces and a long output hold-off");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rbre_pkg.sv
rtl/rbre_ram.sv
rtl/rgba_blend_raster_engine.sv
test/tb_rgba_blend_checker.sv
test/tb_rgba_blend_raster_engine.sv
